### hw/rtl/rotate_sum_checksum_set_macros.svh
// Assertion macros for the rotate-sum checksum set.
// Included by the checker; needs clock and reset names at the place of use.
`ifndef ROTATE_SUM_CHECKSUM_SET_MACROS_SVH
`define ROTATE_SUM_CHECKSUM_SET_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rss check failed");

// Next-cycle implication, disabled during reset
`define RSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rss check failed");

// Next-cycle implication that stays active through reset
`define RSS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rss check failed");

`endif

### hw/rtl/rss_pkg.sv
// Package for the rotate-sum checksum set: codes, command type, rotate-add.
// No dependencies; used by every other file of the block but the macro header.
`timescale 1ns / 1ps

package rss_pkg;

   localparam int SUM_W        = 16;
   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 32;
   localparam int CSR_INDEX_W  = 1;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Input function codes
   typedef enum logic [1:0] {
      FUNC_DATA        = 2'd0,
      FUNC_REPORT      = 2'd1,
      FUNC_CLEAR_EXTRA = 2'd2
   } func_type;

   // Section codes
   typedef enum logic [2:0] {
      SEC_HEADER   = 3'd0,
      SEC_SOLUTION = 3'd1,
      SEC_GRID     = 3'd2,
      SEC_TEXT     = 3'd3,
      SEC_EXTRA    = 3'd4
   } section_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MASK_LOW  = 1'b0,
      CSR_MASK_HIGH = 1'b1
   } csr_index_type;

   // Operation carried from front to back
   typedef enum logic [1:0] {
      OP_ADD         = 2'd0,
      OP_REPORT      = 2'd1,
      OP_CLEAR_EXTRA = 2'd2
   } op_type;

   // Which running sums a data byte updates
   typedef struct packed {
      logic header;
      logic solution;
      logic grid;
      logic secondary;
      logic primary;
      logic extra;
   } sum_hit_type;

   typedef struct packed {
      op_type             op;
      sum_hit_type        hit;
      logic [BYTE_W-1:0]  data;
   } cmd_type;

   // Rotate right by one within 16 bits, then add the byte
   function automatic logic [SUM_W-1:0] rot_add(input logic [SUM_W-1:0] s,
                                                input logic [BYTE_W-1:0] b);
      logic [SUM_W-1:0] r;
      r = {s[0], s[SUM_W-1:1]};
      return r + {{(SUM_W-BYTE_W){1'b0}}, b};
   endfunction

endpackage

### hw/rtl/rss_if.sv
// Channel interfaces for the rotate-sum checksum set: request, response, CSR write.
// Depends on rss_pkg.
`timescale 1ns / 1ps

interface rss_req_if;
   import rss_pkg::*;
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   logic [2:0]          section;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, func, section, data_byte, input ready);
   modport sink   (input valid, func, section, data_byte, output ready);
endinterface

interface rss_rsp_if;
   import rss_pkg::*;
   logic                valid;
   logic                ready;
   logic [SUM_W-1:0]    header_sum;
   logic [SUM_W-1:0]    solution_sum;
   logic [SUM_W-1:0]    grid_sum;
   logic [SUM_W-1:0]    secondary_sum;
   logic [SUM_W-1:0]    primary_sum;
   logic [SUM_W-1:0]    extra_sum;
   logic [WORD_W-1:0]   magic_low_word;
   logic [WORD_W-1:0]   magic_high_word;

   modport source (output valid, header_sum, solution_sum, grid_sum, secondary_sum,
                   primary_sum, extra_sum, magic_low_word, magic_high_word,
                   input ready);
   modport sink   (input valid, header_sum, solution_sum, grid_sum, secondary_sum,
                   primary_sum, extra_sum, magic_low_word, magic_high_word,
                   output ready);
endinterface

interface rss_csr_if;
   import rss_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_INDEX_W-1:0]  index;
   logic [WORD_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/rss_front.sv
// Front end: accepts requests, classifies them into commands for the queue.
// Depends on rss_pkg and rss_if; drops requests that change nothing.
`timescale 1ns / 1ps

module rss_front (
   rss_req_if.sink          req_ch,
   output logic             push_valid,
   input  logic             push_ready,
   output rss_pkg::cmd_type push_cmd
);
   import rss_pkg::*;

   logic        useful;
   sum_hit_type hit;
   op_type      op;

   // Accept whenever the queue has room
   assign req_ch.ready = push_ready;

   // Decode the section into the set of sums it feeds
   always_comb begin
      hit = '0;
      case (req_ch.section)
         SEC_HEADER: begin
            hit.header  = 1'b1;
            hit.primary = 1'b1;
         end
         SEC_SOLUTION: begin
            hit.solution = 1'b1;
            hit.primary  = 1'b1;
         end
         SEC_GRID: begin
            hit.grid    = 1'b1;
            hit.primary = 1'b1;
         end
         SEC_TEXT: begin
            hit.secondary = 1'b1;
            hit.primary   = 1'b1;
         end
         SEC_EXTRA: begin
            hit.extra = 1'b1;
         end
         default: begin
            hit = '0;
         end
      endcase
   end

   // Classify the function; unused codes and unused sections are dropped
   always_comb begin
      op     = OP_ADD;
      useful = 1'b0;
      case (req_ch.func)
         FUNC_DATA: begin
            op     = OP_ADD;
            useful = (hit != '0);
         end
         FUNC_REPORT: begin
            op     = OP_REPORT;
            useful = 1'b1;
         end
         FUNC_CLEAR_EXTRA: begin
            op     = OP_CLEAR_EXTRA;
            useful = 1'b1;
         end
         default: begin
            op     = OP_ADD;
            useful = 1'b0;
         end
      endcase
   end

   assign push_valid    = req_ch.valid && useful;
   assign push_cmd.op   = op;
   assign push_cmd.hit  = hit;
   assign push_cmd.data = req_ch.data_byte;

endmodule

### hw/rtl/rss_queue.sv
// Short command queue between front and back ends.
// Depends on rss_pkg; depth set by the DEPTH parameter (at least 2).
`timescale 1ns / 1ps

module rss_queue #(
   parameter int DEPTH = rss_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rss_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output rss_pkg::cmd_type pop_cmd
);
   import rss_pkg::*;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   cmd_type              entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 push_fire;
   logic                 pop_fire;

   assign push_ready = (count_ff != COUNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write storage
   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/rss_back.sv
// Back end: running sums, mask registers and the response output register.
// Depends on rss_pkg and rss_if.
`timescale 1ns / 1ps

module rss_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  rss_pkg::cmd_type pop_cmd,
   rss_csr_if.sink          csr_ch,
   rss_rsp_if.source        rsp_ch
);
   import rss_pkg::*;

   logic [SUM_W-1:0]  header_ff, header_in;
   logic [SUM_W-1:0]  solution_ff, solution_in;
   logic [SUM_W-1:0]  grid_ff, grid_in;
   logic [SUM_W-1:0]  secondary_ff, secondary_in;
   logic [SUM_W-1:0]  primary_ff, primary_in;
   logic [SUM_W-1:0]  extra_ff, extra_in;
   logic [WORD_W-1:0] mask_low_ff, mask_high_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  out_header_ff, out_solution_ff, out_grid_ff;
   logic [SUM_W-1:0]  out_secondary_ff, out_primary_ff, out_extra_ff;
   logic [WORD_W-1:0] out_magic_low_ff, out_magic_high_ff;

   logic              out_free;
   logic              fire;
   logic              report_fire;

   // A report needs a free output slot; other commands always proceed
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign pop_ready   = out_free || (pop_cmd.op != OP_REPORT);
   assign fire        = pop_valid && pop_ready;
   assign report_fire = fire && (pop_cmd.op == OP_REPORT);

   // Update running sums
   always_comb begin
      header_in    = header_ff;
      solution_in  = solution_ff;
      grid_in      = grid_ff;
      secondary_in = secondary_ff;
      primary_in   = primary_ff;
      extra_in     = extra_ff;
      if (fire) begin
         case (pop_cmd.op)
            OP_ADD: begin
               if (pop_cmd.hit.header)    header_in    = rot_add(header_ff, pop_cmd.data);
               if (pop_cmd.hit.solution)  solution_in  = rot_add(solution_ff, pop_cmd.data);
               if (pop_cmd.hit.grid)      grid_in      = rot_add(grid_ff, pop_cmd.data);
               if (pop_cmd.hit.secondary) secondary_in = rot_add(secondary_ff, pop_cmd.data);
               if (pop_cmd.hit.primary)   primary_in   = rot_add(primary_ff, pop_cmd.data);
               if (pop_cmd.hit.extra)     extra_in     = rot_add(extra_ff, pop_cmd.data);
            end
            OP_REPORT: begin
               header_in    = '0;
               solution_in  = '0;
               grid_in      = '0;
               secondary_in = '0;
               primary_in   = '0;
               extra_in     = '0;
            end
            OP_CLEAR_EXTRA: begin
               extra_in = '0;
            end
            default: begin
               extra_in = extra_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= '0;
         solution_ff  <= '0;
         grid_ff      <= '0;
         secondary_ff <= '0;
         primary_ff   <= '0;
         extra_ff     <= '0;
      end else begin
         header_ff    <= header_in;
         solution_ff  <= solution_in;
         grid_ff      <= grid_in;
         secondary_ff <= secondary_in;
         primary_ff   <= primary_in;
         extra_ff     <= extra_in;
      end
   end

   // Mask registers; writes are always taken
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_low_ff  <= '0;
         mask_high_ff <= '0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MASK_LOW:  mask_low_ff  <= csr_ch.data;
            CSR_MASK_HIGH: mask_high_ff <= csr_ch.data;
            default: begin
               mask_low_ff <= mask_low_ff;
            end
         endcase
      end
   end

   // Hold a result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (report_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture sums and magic words on a report
   always_ff @(posedge clock) begin
      if (report_fire) begin
         out_header_ff     <= header_ff;
         out_solution_ff   <= solution_ff;
         out_grid_ff       <= grid_ff;
         out_secondary_ff  <= secondary_ff;
         out_primary_ff    <= primary_ff;
         out_extra_ff      <= extra_ff;
         out_magic_low_ff  <= {secondary_ff[7:0], grid_ff[7:0],
                               solution_ff[7:0], header_ff[7:0]} ^ mask_low_ff;
         out_magic_high_ff <= {secondary_ff[15:8], grid_ff[15:8],
                               solution_ff[15:8], header_ff[15:8]} ^ mask_high_ff;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.header_sum      = out_header_ff;
   assign rsp_ch.solution_sum    = out_solution_ff;
   assign rsp_ch.grid_sum        = out_grid_ff;
   assign rsp_ch.secondary_sum   = out_secondary_ff;
   assign rsp_ch.primary_sum     = out_primary_ff;
   assign rsp_ch.extra_sum       = out_extra_ff;
   assign rsp_ch.magic_low_word  = out_magic_low_ff;
   assign rsp_ch.magic_high_word = out_magic_high_ff;

endmodule

### hw/rtl/rotate_sum_checksum_set.sv
// Path: a report request is written into the command queue, then its result is
// captured in the response output register. Throughput: one request per cycle,
// set by the back-end rotate-add, while the queue has room; reports wait on a held result.
// Reset (synchronous, active high) clears all sums, both masks, the command
// queue and the response valid; no clearing pass.
`timescale 1ns / 1ps

module rotate_sum_checksum_set #(
   parameter int QUEUE_DEPTH = rss_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rss_req_if.sink    req_ch,
   rss_csr_if.sink    csr_ch,
   rss_rsp_if.source  rsp_ch
);
   import rss_pkg::*;

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   // Classify requests
   rss_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // Decouple front and back
   rss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // Execute commands and drive results
   rss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule

### hw/rtl/rss_checker.sv
// Port-level checks for the rotate-sum checksum set, bound to the top level.
// Depends on rss_pkg and rotate_sum_checksum_set_macros.svh.
`timescale 1ns / 1ps
`include "rotate_sum_checksum_set_macros.svh"

module rss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_magic_low_word,
   input logic [15:0] rsp_header_sum
);
   import rss_pkg::*;

   logic [3:0]  pending_ff, pending_in;
   logic        report_in;
   logic        result_out;
   logic [47:0] rsp_payload;

   assign report_in   = req_valid && req_ready && (req_func == FUNC_REPORT);
   assign result_out  = rsp_valid && rsp_ready;
   assign rsp_payload = {rsp_magic_low_word, rsp_header_sum};

   // Track reports accepted but not yet delivered
   always_comb begin
      pending_in = pending_ff;
      if (report_in && !result_out) begin
         pending_in = pending_ff + 1'b1;
      end else if (result_out && !report_in && pending_ff != '0) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `RSS_ASSERT_ALWAYS_NEXT(a_reset_drops_rsp, clock, reset, !rsp_valid)
   `RSS_ASSERT_NOW(a_rsp_needs_report, clock, reset, rsp_valid, pending_ff != '0)
   `RSS_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind rotate_sum_checksum_set rss_checker u_rss_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .req_func           (req_ch.func),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_magic_low_word (rsp_ch.magic_low_word),
   .rsp_header_sum     (rsp_ch.header_sum)
);
